// ----- src/takf_pkg.sv -----
// Package with shared constants, types and a saturation helper for the tilt Kalman filter.
package takf_pkg;

  localparam int unsigned WordWidthDef = 32;
  localparam int unsigned FracCov      = 24;

  // Configuration register indexes.
  localparam logic [1:0] REG_Q_ANGLE   = 2'd0;
  localparam logic [1:0] REG_Q_GYRO    = 2'd1;
  localparam logic [1:0] REG_R_ANGLE   = 2'd2;
  localparam logic [1:0] REG_STEP_TIME = 2'd3;

  localparam logic [24:0] QAngleRst   = 25'd16777;
  localparam logic [24:0] QGyroRst    = 25'd50332;
  localparam logic [28:0] RAngleRst   = 29'd8388608;
  localparam logic [24:0] StepTimeRst = 25'd83886;
  localparam logic signed [31:0] OneCov = 32'sd16777216;

  // Request to the shared multiply/divide unit.
  typedef struct packed {
    logic        is_div;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } op_req_t;

  // Saturate a 66-bit signed value to an eff-bit signed word, sign-extended to 32.
  function automatic logic signed [31:0] sat_w(input logic signed [65:0] v, input int eff);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = (66'sd1 <<< (eff - 1)) - 66'sd1;
    lo = -hi - 66'sd1;
    if (v > hi) begin
      sat_w = hi[31:0];
    end else if (v < lo) begin
      sat_w = lo[31:0];
    end else begin
      sat_w = v[31:0];
    end
  endfunction

endpackage

// ----- src/takf_muldiv.sv -----
// Shared bit-serial multiplier and restoring divider, one bit per cycle.
module takf_muldiv
  import takf_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = WordWidthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  op_req_t            req,
  output logic               done,
  output logic signed [31:0] result
);

  localparam int Eff = (WORD_WIDTH > 32) ? 32 : WORD_WIDTH;

  logic               busy_r, busy_nxt;
  logic               div_r, div_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic [63:0]        acc_r, acc_nxt;     // product, or quotient bits shifted in
  logic [31:0]        mcand_r, mcand_nxt; // magnitude of multiplicand / divisor
  logic [55:0]        num_r, num_nxt;     // multiplier bits, or dividend bits
  logic [32:0]        rem_r, rem_nxt;
  logic               done_r, done_nxt;
  logic signed [31:0] res_r, res_nxt;

  logic [31:0] mag_a, mag_b;
  logic [33:0] rem_try;
  logic signed [65:0] sres;
  logic [65:0] prod_ext;

  assign mag_a = req.a[31] ? 32'(-req.a) : req.a;
  assign mag_b = req.b[31] ? 32'(-req.b) : req.b;
  assign rem_try = {rem_r, num_r[55]} - {2'b00, mcand_r};

  // Signed result with floor shift for products and truncation for quotients.
  always_comb begin
    prod_ext = {2'b00, acc_r};
    if (div_r) begin
      sres = neg_r ? -$signed(prod_ext) : $signed(prod_ext);
    end else if (neg_r) begin
      sres = (-$signed(prod_ext)) >>> FracCov;
    end else begin
      sres = $signed(prod_ext) >>> FracCov;
    end
  end

  // One shift-add or shift-subtract step per cycle.
  always_comb begin
    busy_nxt  = busy_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    if (start) begin
      busy_nxt  = 1'b1;
      div_nxt   = req.is_div;
      neg_nxt   = req.a[31] ^ req.b[31];
      acc_nxt   = '0;
      mcand_nxt = mag_b;
      rem_nxt   = '0;
      if (req.is_div) begin
        num_nxt = {mag_a, 24'd0};
        cnt_nxt = 6'd56 - 6'd1;
      end else begin
        num_nxt = {24'd0, mag_a};
        cnt_nxt = 6'd31;
      end
    end else if (busy_r) begin
      if (div_r) begin
        if (!rem_try[33]) begin
          rem_nxt = rem_try[32:0];
          acc_nxt = {acc_r[62:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[31:0], num_r[55]};
          acc_nxt = {acc_r[62:0], 1'b0};
        end
        num_nxt = {num_r[54:0], 1'b0};
      end else begin
        acc_nxt = {1'b0, acc_r[63:1]};
        if (num_r[0]) begin
          acc_nxt = {1'b0, acc_r[63:1]} + {1'b0, mcand_r, 31'd0};
        end
        num_nxt = {1'b0, num_r[55:1]};
      end
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
    if (done_r) begin
      res_nxt = sat_w(sres, Eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    div_r   <= div_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    res_r   <= res_nxt;
  end

  // Done is delayed through done_d_r so that it rises together with the registered result.
  logic done_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_d_r <= 1'b0;
    end else begin
      done_d_r <= done_r;
    end
  end
  assign done   = done_d_r;
  assign result = res_r;

endmodule

// ----- src/tilt_angle_kalman_filter.sv -----
// Top level of the tilt Kalman filter: sequencer, state registers and handshakes.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | accel_angle, gyro_rate
//  out_    | output    | out_valid/out_ready| angle_estimate, bias_estimate
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item takes twelve passes through the shared bit-serial unit: ten multiplies
// and two divides, each issued in ST_ISSUE and awaited in ST_WAIT. out_valid
// rises in ST_OUT after the last pass, and the next item follows its transfer.
// A non-positive innovation skips both divides.
// Reset is synchronous and restores the registers and the filter state. The result
// waits in an output register; the next item is taken once it has been transferred.
module tilt_angle_kalman_filter
  import takf_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = WordWidthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_accel_angle,
  input  logic signed [31:0] in_gyro_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_angle_estimate,
  output logic signed [31:0] out_bias_estimate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int Eff = (WORD_WIDTH > 32) ? 32 : WORD_WIDTH;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_OUT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] step_r, step_nxt;

  logic [24:0] q_angle_r, q_gyro_r, step_time_r;
  logic [28:0] r_angle_r;
  logic signed [31:0] angle_r, bias_r, caa_r, cab_r, cba_r, cbb_r;
  logic signed [31:0] angle_nxt, bias_nxt, caa_nxt, cab_nxt, cba_nxt, cbb_nxt;
  logic signed [31:0] meas_r, rate_r, k0_r, k1_r, t0_r, t1_r, err_r, e_r;
  logic signed [31:0] meas_nxt, rate_nxt, k0_nxt, k1_nxt, t0_nxt, t1_nxt, err_nxt, e_nxt;

  op_req_t req;
  logic mu_start, mu_done;
  logic signed [31:0] mu_res;
  logic signed [31:0] dt_s;

  takf_muldiv #(.WORD_WIDTH(WORD_WIDTH)) u_muldiv (
    .clk(clk), .rst_n(rst_n), .start(mu_start), .req(req),
    .done(mu_done), .result(mu_res)
  );

  assign dt_s      = $signed({7'd0, step_time_r});
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == ST_OUT);
  assign out_angle_estimate = angle_r;
  assign out_bias_estimate  = bias_r;

  // Operand selection for each step of the update.
  always_comb begin
    req = '{is_div: 1'b0, a: 32'sd0, b: dt_s};
    case (step_r)
      4'd0:  req.a = sat_w(66'(rate_r) - 66'(bias_r), Eff);
      4'd1:  req.a = sat_w(66'($signed({7'd0, q_angle_r})) - 66'(cab_r) - 66'(cba_r), Eff);
      4'd2:  req.a = sat_w(-66'(cbb_r), Eff);
      4'd3:  req.a = $signed({7'd0, q_gyro_r});
      4'd4:  req = '{is_div: 1'b1, a: caa_r, b: e_r};
      4'd5:  req = '{is_div: 1'b1, a: cba_r, b: e_r};
      4'd6:  req = '{is_div: 1'b0, a: k0_r, b: t0_r};
      4'd7:  req = '{is_div: 1'b0, a: k0_r, b: t1_r};
      4'd8:  req = '{is_div: 1'b0, a: k1_r, b: t0_r};
      4'd9:  req = '{is_div: 1'b0, a: k1_r, b: t1_r};
      4'd10: req = '{is_div: 1'b0, a: k0_r, b: err_r};
      4'd11: req = '{is_div: 1'b0, a: k1_r, b: err_r};
      default: req = '{is_div: 1'b0, a: 32'sd0, b: dt_s};
    endcase
  end

  // Sequencer: issue one operation, wait, fold the result into the state.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    mu_start  = 1'b0;
    angle_nxt = angle_r; bias_nxt = bias_r;
    caa_nxt = caa_r; cab_nxt = cab_r; cba_nxt = cba_r; cbb_nxt = cbb_r;
    meas_nxt = meas_r; rate_nxt = rate_r; k0_nxt = k0_r; k1_nxt = k1_r;
    t0_nxt = t0_r; t1_nxt = t1_r; err_nxt = err_r; e_nxt = e_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          meas_nxt  = sat_w(66'(in_accel_angle), Eff);
          rate_nxt  = sat_w(66'(in_gyro_rate), Eff);
          step_nxt  = 4'd0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        // Gains are zero when the innovation is not positive.
        if ((step_r == 4'd4 || step_r == 4'd5) && e_r <= 32'sd0) begin
          k0_nxt = 32'sd0;
          k1_nxt = 32'sd0;
          step_nxt = 4'd6;
        end else begin
          mu_start  = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mu_done) begin
          case (step_r)
            4'd0: angle_nxt = sat_w(66'(angle_r) + 66'(mu_res), Eff);
            4'd1: caa_nxt = sat_w(66'(caa_r) + 66'(mu_res), Eff);
            4'd2: begin
              cab_nxt = sat_w(66'(cab_r) + 66'(mu_res), Eff);
              cba_nxt = sat_w(66'(cba_r) + 66'(mu_res), Eff);
            end
            4'd3: begin
              cbb_nxt = sat_w(66'(cbb_r) + 66'(mu_res), Eff);
              err_nxt = sat_w(66'(meas_r) - 66'(angle_r), Eff);
              e_nxt   = sat_w(66'($signed({3'd0, r_angle_r})) + 66'(caa_r), Eff);
              t0_nxt  = caa_r;
              t1_nxt  = cab_r;
            end
            4'd4: k0_nxt = mu_res;
            4'd5: k1_nxt = mu_res;
            4'd6: caa_nxt = sat_w(66'(caa_r) - 66'(mu_res), Eff);
            4'd7: cab_nxt = sat_w(66'(cab_r) - 66'(mu_res), Eff);
            4'd8: cba_nxt = sat_w(66'(cba_r) - 66'(mu_res), Eff);
            4'd9: cbb_nxt = sat_w(66'(cbb_r) - 66'(mu_res), Eff);
            4'd10: angle_nxt = sat_w(66'(angle_r) + 66'(mu_res), Eff);
            4'd11: bias_nxt = sat_w(66'(bias_r) + 66'(mu_res), Eff);
            default: ;
          endcase
          if (step_r == 4'd11) begin
            state_nxt = ST_OUT;
          end else begin
            step_nxt  = step_r + 4'd1;
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control, configuration and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 4'd0;
      q_angle_r   <= QAngleRst;
      q_gyro_r    <= QGyroRst;
      r_angle_r   <= RAngleRst;
      step_time_r <= StepTimeRst;
      angle_r <= '0; bias_r <= '0;
      caa_r <= OneCov; cab_r <= '0; cba_r <= '0; cbb_r <= OneCov;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      angle_r <= angle_nxt; bias_r <= bias_nxt;
      caa_r <= caa_nxt; cab_r <= cab_nxt; cba_r <= cba_nxt; cbb_r <= cbb_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_Q_ANGLE:   q_angle_r   <= cfg_data[24:0];
          REG_Q_GYRO:    q_gyro_r    <= cfg_data[24:0];
          REG_R_ANGLE:   r_angle_r   <= cfg_data[28:0];
          REG_STEP_TIME: step_time_r <= cfg_data[24:0];
          default: ;
        endcase
      end
    end
    meas_r <= meas_nxt; rate_r <= rate_nxt; k0_r <= k0_nxt; k1_r <= k1_nxt;
    t0_r <= t0_nxt; t1_r <= t1_nxt; err_r <= err_nxt; e_r <= e_nxt;
  end

endmodule
